[design/mpm_pkg.sv]
`default_nettype none
package mpm_pkg;

   localparam int MAX_NODES_DEF   = 1024;
   localparam int ALPHABET        = 64;
   localparam int MAX_PATTERN_LEN = 32;
   localparam int MAX_PATTERNS    = 256;
   localparam int RESULT_CAP      = 32;

   localparam int OP_W    = 2;
   localparam int SYM_W   = 6;
   localparam int KIND_W  = 2;
   localparam int POS_W   = 32;
   localparam int NUM_W   = 9;
   localparam int DEPTH_W = 6;
   localparam int PAT_W   = 8;
   localparam int CNT_W   = 6;

   localparam logic [OP_W-1:0] OP_PAT_SYM = 2'd0;
   localparam logic [OP_W-1:0] OP_PAT_END = 2'd1;
   localparam logic [OP_W-1:0] OP_TEXT    = 2'd2;

   localparam logic [KIND_W-1:0] KIND_MATCH    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [SYM_W-1:0] symbol;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  start_position;
      logic [NUM_W-1:0]  pattern_number;
      logic              last;
   } rsp_type;

   typedef enum logic [1:0] {
      IK_PAT_SYM,
      IK_PAT_END,
      IK_TEXT
   } item_kind_type;

   typedef struct packed {
      logic             valid;
      item_kind_type    kind;
      logic [SYM_W-1:0] symbol;
   } qent_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PS_CHK,
      ST_END,
      ST_RB_INFO,
      ST_RB_CHK,
      ST_RB_FP,
      ST_RB_CCHK,
      ST_GO_RD,
      ST_GO_CHK,
      ST_GO_FL,
      ST_WK_RD,
      ST_WK_CHK,
      ST_WK_LAST
   } eng_state_type;

endpackage
`default_nettype wire

[design/mpm_front.sv]
`default_nettype none
module mpm_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mpm_pkg::req_type req_item,
   input  wire logic             hold,
   input  wire logic             pop,
   output mpm_pkg::qent_type     head
);

   typedef struct packed {
      mpm_pkg::item_kind_type          kind;
      logic [mpm_pkg::SYM_W-1:0]       symbol;
   } slot_type;

   slot_type    slot_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        accept, keep;
   slot_type    slot_in;

   assign req_ready = !hold && (count_ff != 2'd2);
   assign accept    = req_valid && req_ready;

   always_comb begin
      keep        = 1'b1;
      slot_in.kind   = mpm_pkg::IK_TEXT;
      slot_in.symbol = req_item.symbol;
      case (req_item.opcode)
         mpm_pkg::OP_PAT_SYM: slot_in.kind = mpm_pkg::IK_PAT_SYM;
         mpm_pkg::OP_PAT_END: slot_in.kind = mpm_pkg::IK_PAT_END;
         mpm_pkg::OP_TEXT:    slot_in.kind = mpm_pkg::IK_TEXT;
         default:             keep = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (accept && keep) begin
            slot_ff[wr_ptr_ff] <= slot_in;
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'((accept && keep) ? 1 : 0) - 2'(pop ? 1 : 0);
      end
   end

   always_comb begin
      head.valid  = (count_ff != 2'd0);
      head.kind   = slot_ff[rd_ptr_ff].kind;
      head.symbol = slot_ff[rd_ptr_ff].symbol;
   end

endmodule
`default_nettype wire

[design/mpm_engine.sv]
`default_nettype none
module mpm_engine #(
   parameter int MAX_NODES = mpm_pkg::MAX_NODES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mpm_pkg::qent_type head,
   output logic                   pop,
   output logic                   clearing,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mpm_pkg::rsp_type       rsp_item
);

   localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int SYM_W   = mpm_pkg::SYM_W;
   localparam int DEPTH_W = mpm_pkg::DEPTH_W;
   localparam int CA_W    = NODE_W + SYM_W;
   localparam int CHILD_N = MAX_NODES * (2 ** SYM_W);
   localparam int INFO_W  = NODE_W + SYM_W + DEPTH_W;
   localparam int TERM_W  = 1 + mpm_pkg::PAT_W;
   localparam int POS_W   = mpm_pkg::POS_W;
   localparam int NUM_W   = mpm_pkg::NUM_W;
   localparam int CNT_W   = mpm_pkg::CNT_W;

   logic [NODE_W:0]   child_mem [CHILD_N];
   logic [INFO_W-1:0] info_mem  [MAX_NODES];
   logic [TERM_W-1:0] term_mem  [MAX_NODES];
   logic [NODE_W-1:0] fail_mem  [MAX_NODES];

   logic [NODE_W:0]   child_rd_ff, child_wd;
   logic [CA_W-1:0]   child_ra, child_wa;
   logic              child_we;
   logic [INFO_W-1:0] info_rd_ff, info_wd;
   logic [NODE_W-1:0] info_ra, info_wa;
   logic              info_we;
   logic [TERM_W-1:0] term_rd_ff, term_wd;
   logic [NODE_W-1:0] term_ra, term_wa;
   logic              term_we;
   logic [NODE_W-1:0] fail_rd_ff, fail_wd;
   logic [NODE_W-1:0] fail_ra, fail_wa;
   logic              fail_we;

   always_ff @(posedge clock) begin
      if (child_we) begin
         child_mem[child_wa] <= child_wd;
      end
      child_rd_ff <= child_mem[child_ra];
      if (info_we) begin
         info_mem[info_wa] <= info_wd;
      end
      info_rd_ff <= info_mem[info_ra];
      if (term_we) begin
         term_mem[term_wa] <= term_wd;
      end
      term_rd_ff <= term_mem[term_ra];
      if (fail_we) begin
         fail_mem[fail_wa] <= fail_wd;
      end
      fail_rd_ff <= fail_mem[fail_ra];
   end

   mpm_pkg::eng_state_type state_ff, state_in;
   logic [CA_W-1:0]    clr_ff, clr_in;
   logic [NODE_W:0]    node_count_ff, node_count_in;
   logic [NODE_W-1:0]  insert_node_ff, insert_node_in;
   logic [DEPTH_W-1:0] insert_depth_ff, insert_depth_in;
   logic               ovf_ff, ovf_in;
   logic [NUM_W-1:0]   pattern_count_ff, pattern_count_in;
   logic [NODE_W-1:0]  cur_ff, cur_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               dirty_ff, dirty_in;
   logic [DEPTH_W-1:0] max_depth_ff, max_depth_in;
   logic [SYM_W-1:0]   sym_ff, sym_in;
   logic [NODE_W-1:0]  u_ff, u_in;
   logic [NODE_W:0]    v_ff, v_in;
   logic [DEPTH_W-1:0] d_ff, d_in;
   logic [SYM_W-1:0]   vsym_ff, vsym_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic               pend_ff, pend_in;
   logic [POS_W-1:0]   pend_start_ff, pend_start_in;
   logic [NUM_W-1:0]   pend_num_ff, pend_num_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mpm_pkg::rsp_type   rsp_ff, rsp_in;

   logic               out_free;
   logic [NODE_W-1:0]  new_node;
   logic [DEPTH_W-1:0] next_depth;
   logic [NODE_W-1:0]  rd_parent;
   logic [SYM_W-1:0]   rd_sym;
   logic [DEPTH_W-1:0] rd_depth;
   logic [POS_W:0]     end_pos, start_wide;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign new_node   = node_count_ff[NODE_W-1:0];
   assign next_depth = insert_depth_ff + DEPTH_W'(1);
   assign rd_parent  = info_rd_ff[INFO_W-1 -: NODE_W];
   assign rd_sym     = info_rd_ff[SYM_W+DEPTH_W-1 -: SYM_W];
   assign rd_depth   = info_rd_ff[DEPTH_W-1:0];
   assign end_pos    = {1'b0, pos_ff} + (POS_W+1)'(1);
   assign start_wide = (end_pos > (POS_W+1)'(rd_depth)) ? end_pos - (POS_W+1)'(rd_depth)
                                                         : '0;

   always_comb begin
      state_in         = state_ff;
      clr_in           = clr_ff;
      node_count_in    = node_count_ff;
      insert_node_in   = insert_node_ff;
      insert_depth_in  = insert_depth_ff;
      ovf_in           = ovf_ff;
      pattern_count_in = pattern_count_ff;
      cur_in           = cur_ff;
      pos_in           = pos_ff;
      dirty_in         = dirty_ff;
      max_depth_in     = max_depth_ff;
      sym_in           = sym_ff;
      u_in             = u_ff;
      v_in             = v_ff;
      d_in             = d_ff;
      vsym_in          = vsym_ff;
      n_in             = n_ff;
      pend_in          = pend_ff;
      pend_start_in    = pend_start_ff;
      pend_num_in      = pend_num_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_in           = rsp_ff;
      pop              = 1'b0;
      child_ra = '0; child_wa = '0; child_wd = '0; child_we = 1'b0;
      info_ra  = '0; info_wa  = '0; info_wd  = '0; info_we  = 1'b0;
      term_ra  = '0; term_wa  = '0; term_wd  = '0; term_we  = 1'b0;
      fail_ra  = '0; fail_wa  = '0; fail_wd  = '0; fail_we  = 1'b0;

      case (state_ff)
         mpm_pkg::ST_CLEAR: begin
            child_we = 1'b1;
            child_wa = clr_ff;
            clr_in   = clr_ff + CA_W'(1);
            if (clr_ff == '1) begin
               state_in = mpm_pkg::ST_IDLE;
            end
         end
         mpm_pkg::ST_IDLE: begin
            if (head.valid) begin
               pop    = 1'b1;
               sym_in = head.symbol;
               case (head.kind)
                  mpm_pkg::IK_PAT_SYM: begin
                     if (!ovf_ff) begin
                        if ({1'b0, head.symbol} >= (SYM_W+1)'(mpm_pkg::ALPHABET) ||
                            insert_depth_ff >= DEPTH_W'(mpm_pkg::MAX_PATTERN_LEN)) begin
                           ovf_in = 1'b1;
                        end else begin
                           child_ra = {insert_node_ff, head.symbol};
                           state_in = mpm_pkg::ST_PS_CHK;
                        end
                     end
                  end
                  mpm_pkg::IK_PAT_END: state_in = mpm_pkg::ST_END;
                  mpm_pkg::IK_TEXT: begin
                     if (pos_ff != '1) begin
                        pos_in = pos_ff + POS_W'(1);
                     end
                     if ({1'b0, head.symbol} >= (SYM_W+1)'(mpm_pkg::ALPHABET)) begin
                        cur_in = '0;
                     end else if (dirty_ff) begin
                        d_in     = DEPTH_W'(1);
                        v_in     = (NODE_W+1)'(1);
                        state_in = mpm_pkg::ST_RB_INFO;
                     end else begin
                        u_in     = cur_ff;
                        state_in = mpm_pkg::ST_GO_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         mpm_pkg::ST_PS_CHK: begin
            state_in = mpm_pkg::ST_IDLE;
            if (child_rd_ff[NODE_W]) begin
               insert_node_in  = child_rd_ff[NODE_W-1:0];
               insert_depth_in = next_depth;
            end else if (node_count_ff >= (NODE_W+1)'(MAX_NODES)) begin
               ovf_in = 1'b1;
            end else begin
               info_we  = 1'b1;
               info_wa  = new_node;
               info_wd  = {insert_node_ff, sym_ff, next_depth};
               term_we  = 1'b1;
               term_wa  = new_node;
               term_wd  = '0;
               child_we = 1'b1;
               child_wa = {insert_node_ff, sym_ff};
               child_wd = {1'b1, new_node};
               dirty_in        = 1'b1;
               insert_node_in  = new_node;
               insert_depth_in = next_depth;
               node_count_in   = node_count_ff + (NODE_W+1)'(1);
               if (next_depth > max_depth_ff) begin
                  max_depth_in = next_depth;
               end
            end
         end
         mpm_pkg::ST_END: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.start_position = '0;
               rsp_in.last = 1'b1;
               if (!ovf_ff && pattern_count_ff < NUM_W'(mpm_pkg::MAX_PATTERNS)) begin
                  term_we = 1'b1;
                  term_wa = insert_node_ff;
                  term_wd = {1'b1, pattern_count_ff[mpm_pkg::PAT_W-1:0]};
                  pattern_count_in      = pattern_count_ff + NUM_W'(1);
                  rsp_in.kind           = mpm_pkg::KIND_ACCEPTED;
                  rsp_in.pattern_number = pattern_count_ff + NUM_W'(1);
               end else begin
                  rsp_in.kind           = mpm_pkg::KIND_REJECTED;
                  rsp_in.pattern_number = '0;
               end
               insert_node_in  = '0;
               insert_depth_in = '0;
               ovf_in          = 1'b0;
               state_in        = mpm_pkg::ST_IDLE;
            end
         end
         mpm_pkg::ST_RB_INFO: begin
            if (v_ff >= node_count_ff) begin
               if (d_ff >= max_depth_ff) begin
                  dirty_in = 1'b0;
                  u_in     = cur_ff;
                  state_in = mpm_pkg::ST_GO_RD;
               end else begin
                  d_in = d_ff + DEPTH_W'(1);
                  v_in = (NODE_W+1)'(1);
               end
            end else begin
               info_ra  = v_ff[NODE_W-1:0];
               state_in = mpm_pkg::ST_RB_CHK;
            end
         end
         mpm_pkg::ST_RB_CHK: begin
            if (rd_depth != d_ff) begin
               v_in     = v_ff + (NODE_W+1)'(1);
               state_in = mpm_pkg::ST_RB_INFO;
            end else if (rd_parent == '0) begin
               fail_we  = 1'b1;
               fail_wa  = v_ff[NODE_W-1:0];
               v_in     = v_ff + (NODE_W+1)'(1);
               state_in = mpm_pkg::ST_RB_INFO;
            end else begin
               vsym_in  = rd_sym;
               fail_ra  = rd_parent;
               state_in = mpm_pkg::ST_RB_FP;
            end
         end
         mpm_pkg::ST_RB_FP: begin
            u_in     = fail_rd_ff;
            child_ra = {fail_rd_ff, vsym_ff};
            state_in = mpm_pkg::ST_RB_CCHK;
         end
         mpm_pkg::ST_RB_CCHK: begin
            if (child_rd_ff[NODE_W] || u_ff == '0) begin
               fail_we  = 1'b1;
               fail_wa  = v_ff[NODE_W-1:0];
               fail_wd  = child_rd_ff[NODE_W] ? child_rd_ff[NODE_W-1:0] : '0;
               v_in     = v_ff + (NODE_W+1)'(1);
               state_in = mpm_pkg::ST_RB_INFO;
            end else begin
               fail_ra  = u_ff;
               state_in = mpm_pkg::ST_RB_FP;
            end
         end
         mpm_pkg::ST_GO_RD: begin
            child_ra = {u_ff, sym_ff};
            state_in = mpm_pkg::ST_GO_CHK;
         end
         mpm_pkg::ST_GO_CHK: begin
            if (child_rd_ff[NODE_W]) begin
               cur_in   = child_rd_ff[NODE_W-1:0];
               u_in     = child_rd_ff[NODE_W-1:0];
               n_in     = '0;
               pend_in  = 1'b0;
               state_in = mpm_pkg::ST_WK_RD;
            end else if (u_ff == '0) begin
               cur_in   = '0;
               state_in = mpm_pkg::ST_IDLE;
            end else begin
               fail_ra  = u_ff;
               state_in = mpm_pkg::ST_GO_FL;
            end
         end
         mpm_pkg::ST_GO_FL: begin
            u_in     = fail_rd_ff;
            child_ra = {fail_rd_ff, sym_ff};
            state_in = mpm_pkg::ST_GO_CHK;
         end
         mpm_pkg::ST_WK_RD: begin
            if (u_ff == '0 || n_ff == CNT_W'(mpm_pkg::RESULT_CAP)) begin
               state_in = pend_ff ? mpm_pkg::ST_WK_LAST : mpm_pkg::ST_IDLE;
            end else begin
               term_ra  = u_ff;
               info_ra  = u_ff;
               fail_ra  = u_ff;
               state_in = mpm_pkg::ST_WK_CHK;
            end
         end
         mpm_pkg::ST_WK_CHK: begin
            term_ra = u_ff;
            info_ra = u_ff;
            fail_ra = u_ff;
            if (!term_rd_ff[TERM_W-1]) begin
               u_in     = fail_rd_ff;
               state_in = mpm_pkg::ST_WK_RD;
            end else if (!pend_ff || out_free) begin
               if (pend_ff) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.kind           = mpm_pkg::KIND_MATCH;
                  rsp_in.start_position = pend_start_ff;
                  rsp_in.pattern_number = pend_num_ff;
                  rsp_in.last           = 1'b0;
               end
               pend_in       = 1'b1;
               pend_start_in = start_wide[POS_W-1:0];
               pend_num_in   = {1'b0, term_rd_ff[mpm_pkg::PAT_W-1:0]} + NUM_W'(1);
               n_in          = n_ff + CNT_W'(1);
               u_in          = fail_rd_ff;
               state_in      = mpm_pkg::ST_WK_RD;
            end
         end
         mpm_pkg::ST_WK_LAST: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.kind           = mpm_pkg::KIND_MATCH;
               rsp_in.start_position = pend_start_ff;
               rsp_in.pattern_number = pend_num_ff;
               rsp_in.last           = 1'b1;
               pend_in               = 1'b0;
               state_in              = mpm_pkg::ST_IDLE;
            end
         end
         default: state_in = mpm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= mpm_pkg::ST_CLEAR;
         clr_ff           <= '0;
         node_count_ff    <= (NODE_W+1)'(1);
         insert_node_ff   <= '0;
         insert_depth_ff  <= '0;
         ovf_ff           <= 1'b0;
         pattern_count_ff <= '0;
         cur_ff           <= '0;
         pos_ff           <= '0;
         dirty_ff         <= 1'b0;
         max_depth_ff     <= '0;
         pend_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clr_ff           <= clr_in;
         node_count_ff    <= node_count_in;
         insert_node_ff   <= insert_node_in;
         insert_depth_ff  <= insert_depth_in;
         ovf_ff           <= ovf_in;
         pattern_count_ff <= pattern_count_in;
         cur_ff           <= cur_in;
         pos_ff           <= pos_in;
         dirty_ff         <= dirty_in;
         max_depth_ff     <= max_depth_in;
         pend_ff          <= pend_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      sym_ff        <= sym_in;
      u_ff          <= u_in;
      v_ff          <= v_in;
      d_ff          <= d_in;
      vsym_ff       <= vsym_in;
      n_ff          <= n_in;
      pend_start_ff <= pend_start_in;
      pend_num_ff   <= pend_num_in;
      rsp_ff        <= rsp_in;
   end

   assign clearing  = (state_ff == mpm_pkg::ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_node_count: assert property (@(posedge clock) disable iff (reset)
      node_count_ff != '0 && node_count_ff <= (NODE_W+1)'(MAX_NODES))
      else $error("node count out of range");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == mpm_pkg::ST_CLEAR |-> !rsp_valid_ff && !pop)
      else $error("activity during clearing pass");

   a_insert_depth: assert property (@(posedge clock) disable iff (reset)
      insert_depth_ff <= DEPTH_W'(mpm_pkg::MAX_PATTERN_LEN))
      else $error("insertion depth beyond length limit");

   a_walk_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_W'(mpm_pkg::RESULT_CAP) || state_ff != mpm_pkg::ST_WK_RD)
      else $error("match count beyond cap");

endmodule
`default_nettype wire

[design/multi_pattern_matcher_core.sv]
// Aho-Corasick multi-pattern matcher.
// Input channel req_: items carry an opcode and a symbol. Pattern symbol items
// grow the trie, an end-of-pattern item gives one status result (accepted with
// its number, or rejected), and text symbol items give one match result per
// terminal node on the suffix chain of the reached state, deepest first, up to
// RESULT_CAP (32), with last set on the final one. Text with no match and
// opcode 3 give no result. Output channel rsp_: one registered result stage; a
// stalled receiver holds the engine at its next result while up to two items
// still queue at the input. The engine takes one item at a time: a pattern
// symbol reads its child entry and then adds a node if there is none, an end of
// pattern writes its status result, and a text symbol runs the goto search with
// one suffix-link hop per step, then walks the chain node by node, closes the
// walk and sends the final match when there is one. The first text item after
// trie growth first rebuilds the suffix links: for each trie depth it scans
// every node, and for the nodes at that depth follows suffix links from the
// parent. The node and child memories each have a single registered read port.
// Reset: a clearing pass wipes every child memory entry; no item is accepted
// until it ends.
`default_nettype none
module multi_pattern_matcher_core #(
   parameter int MAX_NODES = mpm_pkg::MAX_NODES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mpm_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mpm_pkg::rsp_type      rsp_item
);

   mpm_pkg::qent_type head;
   logic              pop;
   logic              clearing;

   mpm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .hold      (clearing),
      .pop       (pop),
      .head      (head)
   );

   mpm_engine #(
      .MAX_NODES (MAX_NODES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire

[sim/multi_pattern_matcher_core_tb.sv]
`timescale 1ns / 1ps
module multi_pattern_matcher_core_tb;

   localparam int NODES = mpm_pkg::MAX_NODES_DEF;
   localparam int ALPHA = mpm_pkg::ALPHABET;
   localparam logic [mpm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   mpm_pkg::req_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   mpm_pkg::rsp_type rsp_item;

   multi_pattern_matcher_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item)
   );

   mpm_pkg::req_type pending[$];
   mpm_pkg::rsp_type expected[$];
   logic req_taken = 1'b0;
   int n_accepted = 0;
   int n_errors = 0;
   int idle_cycles = 0;
   int hold = 0;
   bit held_once = 0;
   int n_text = 0, n_matches = 0, n_ok = 0, n_rej = 0;

   // trie and automaton state
   int child[NODES*ALPHA];
   int go_memo[NODES*ALPHA];
   int go_gen[NODES*ALPHA];
   int sfx_memo[NODES];
   int sfx_gen[NODES];
   int par[NODES];
   int nsym[NODES];
   int ndepth[NODES];
   bit nterm[NODES];
   int npat[NODES];
   int gen = 1;
   int node_total = 1;
   int ins = 0;
   bit ins_ovf = 0;
   int pat_total = 0;
   int cur = 0;
   logic [mpm_pkg::POS_W-1:0] pos = '0;

   wire calm = n_accepted >= 200 && n_accepted < 380;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int suffix_link(int v);
      if (sfx_gen[v] != gen) begin
         sfx_memo[v] = (v == 0 || par[v] == 0) ? 0 : goto_move(suffix_link(par[v]), nsym[v]);
         sfx_gen[v] = gen;
      end
      return sfx_memo[v];
   endfunction

   function automatic int goto_move(int v, int s);
      int at;
      at = v * ALPHA + s;
      if (go_gen[at] != gen) begin
         if (child[at] >= 0) go_memo[at] = child[at];
         else if (v == 0) go_memo[at] = 0;
         else go_memo[at] = goto_move(suffix_link(v), s);
         go_gen[at] = gen;
      end
      return go_memo[at];
   endfunction

   task automatic predict_matches(mpm_pkg::req_type it);
      int at, n, i;
      mpm_pkg::rsp_type r;
      bit have;
      logic [mpm_pkg::POS_W:0] fin;
      case (it.opcode)
         mpm_pkg::OP_PAT_SYM: begin
            if (ins_ovf) return;
            if (it.symbol >= ALPHA || ndepth[ins] >= mpm_pkg::MAX_PATTERN_LEN) begin
               ins_ovf = 1;
               return;
            end
            at = ins * ALPHA + it.symbol;
            if (child[at] < 0) begin
               if (node_total >= NODES) begin
                  ins_ovf = 1;
                  return;
               end
               par[node_total] = ins;
               nsym[node_total] = it.symbol;
               ndepth[node_total] = ndepth[ins] + 1;
               nterm[node_total] = 0;
               child[at] = node_total;
               node_total++;
               gen++;
            end
            ins = child[at];
         end
         mpm_pkg::OP_PAT_END: begin
            r = '0;
            r.last = 1'b1;
            if (!ins_ovf && pat_total < mpm_pkg::MAX_PATTERNS) begin
               nterm[ins] = 1;
               npat[ins] = pat_total;
               pat_total++;
               gen++;
               r.kind = mpm_pkg::KIND_ACCEPTED;
               r.pattern_number = mpm_pkg::NUM_W'(pat_total);
               n_ok++;
            end else begin
               r.kind = mpm_pkg::KIND_REJECTED;
               n_rej++;
            end
            expected.insert(expected.size(), r);
            ins = 0;
            ins_ovf = 0;
         end
         mpm_pkg::OP_TEXT: begin
            n_text++;
            if (pos != '1) pos++;
            if (it.symbol >= ALPHA) begin
               cur = 0;
               return;
            end
            cur = goto_move(cur, it.symbol);
            n = 0;
            have = 0;
            fin = {1'b0, pos} + 1;
            for (i = cur; i != 0 && n < mpm_pkg::RESULT_CAP; i = suffix_link(i)) begin
               if (nterm[i]) begin
                  if (have) expected.insert(expected.size(), r);
                  r.kind = mpm_pkg::KIND_MATCH;
                  r.start_position = (fin > ndepth[i]) ?
                                     mpm_pkg::POS_W'(fin - ndepth[i]) : '0;
                  r.pattern_number = mpm_pkg::NUM_W'(npat[i] + 1);
                  r.last = 1'b0;
                  have = 1;
                  n++;
               end
            end
            if (have) begin
               r.last = 1'b1;
               expected.insert(expected.size(), r);
            end
            n_matches += n;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      mpm_pkg::rsp_type e;
      req_taken <= req_valid && req_ready;
      if (req_valid && req_ready) begin
         n_accepted++;
         predict_matches(req_item);
      end
      if (rsp_valid && rsp_ready) begin
         if (expected.size() == 0) begin
            $error("unexpected result kind=%0d pos=%0d num=%0d", rsp_item.kind,
                   rsp_item.start_position, rsp_item.pattern_number);
            n_errors++;
         end else begin
            e = expected.pop_front();
            if (rsp_item.kind !== e.kind) begin
               $error("kind: expected %0d, got %0d", e.kind, rsp_item.kind);
               n_errors++;
            end
            if (rsp_item.start_position !== e.start_position) begin
               $error("start_position: expected %0d, got %0d", e.start_position,
                      rsp_item.start_position);
               n_errors++;
            end
            if (rsp_item.pattern_number !== e.pattern_number) begin
               $error("pattern_number: expected %0d, got %0d", e.pattern_number,
                      rsp_item.pattern_number);
               n_errors++;
            end
            if (rsp_item.last !== e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp_item.last);
               n_errors++;
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
            req_valid <= 1'b1;
            req_item <= pending.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold > 0) begin
         rsp_ready <= 1'b0;
         hold <= hold - 1;
      end else if (!held_once && n_accepted >= 40) begin
         rsp_ready <= 1'b0;
         hold <= 400;
         held_once <= 1;
      end else begin
         rsp_ready <= calm || $urandom_range(99) >= 27;
      end
   end

   task automatic add(logic [mpm_pkg::OP_W-1:0] op, int s);
      mpm_pkg::req_type it;
      it.opcode = op;
      it.symbol = mpm_pkg::SYM_W'(s);
      pending.insert(pending.size(), it);
   endtask

   function automatic int pick_symbol();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(3);
      if (r < 80) return ALPHA - 1;
      return $urandom_range(ALPHA - 1);
   endfunction

   task automatic add_pattern(int len, bit wide);
      for (int k = 0; k < len; k++)
         add(mpm_pkg::OP_PAT_SYM, wide ? $urandom_range(ALPHA - 1) : pick_symbol());
      add(mpm_pkg::OP_PAT_END, $urandom_range(ALPHA - 1));
   endtask

   initial begin
      int r;
      for (int k = 0; k < NODES*ALPHA; k++) begin
         child[k] = -1;
         go_gen[k] = 0;
      end
      for (int k = 0; k < NODES; k++) begin
         sfx_gen[k] = 0;
         ndepth[k] = 0;
         nterm[k] = 0;
      end

      add(OP_UNUSED, 5);
      add(mpm_pkg::OP_PAT_END, 63);
      add(mpm_pkg::OP_PAT_SYM, 0); add(mpm_pkg::OP_PAT_SYM, 1); add(mpm_pkg::OP_PAT_END, 0);
      add(mpm_pkg::OP_PAT_SYM, 1); add(mpm_pkg::OP_PAT_END, 0);
      add(mpm_pkg::OP_PAT_SYM, 63); add(mpm_pkg::OP_PAT_SYM, 42); add(mpm_pkg::OP_PAT_END, 21);
      add(mpm_pkg::OP_PAT_SYM, 0); add(mpm_pkg::OP_PAT_SYM, 1); add(mpm_pkg::OP_PAT_END, 0);
      add(mpm_pkg::OP_TEXT, 0); add(mpm_pkg::OP_TEXT, 1); add(mpm_pkg::OP_TEXT, 1);
      add(mpm_pkg::OP_TEXT, 63); add(mpm_pkg::OP_TEXT, 42); add(mpm_pkg::OP_TEXT, 21);
      add(OP_UNUSED, 58);
      add(mpm_pkg::OP_TEXT, 0); add(mpm_pkg::OP_TEXT, 1);

      while (pending.size() < 90) begin
         r = $urandom_range(99);
         if (r < 45) add_pattern($urandom_range(1, 4), 0);
         else if (r < 85)
            repeat ($urandom_range(1, 12)) add(mpm_pkg::OP_TEXT, pick_symbol());
         else if (r < 92)
            add(r[0] ? OP_UNUSED : mpm_pkg::OP_PAT_END, $urandom_range(ALPHA - 1));
         else if (r < 96) add_pattern($urandom_range(33, 36), 0);
         else repeat ($urandom_range(1, 3)) add(mpm_pkg::OP_PAT_SYM, pick_symbol());
      end

      for (int k = 1; k <= 10; k++) begin
         repeat (k) add(mpm_pkg::OP_PAT_SYM, 0);
         add(mpm_pkg::OP_PAT_END, 0);
      end
      repeat (20) add(mpm_pkg::OP_TEXT, 0);

      add_pattern(mpm_pkg::MAX_PATTERN_LEN + 2, 1);
      repeat (6) add(mpm_pkg::OP_TEXT, pick_symbol());
      repeat (250) add(mpm_pkg::OP_PAT_END, 0);
      repeat (6) add(mpm_pkg::OP_TEXT, pick_symbol());

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending.size() == 0 && !req_valid);
      wait (expected.size() == 0);
      repeat (300) @(posedge clock);
      $display("%0d items taken: %0d text symbols, %0d matches, %0d patterns accepted, %0d rejected",
               n_accepted, n_text, n_matches, n_ok, n_rej);
      $display("trie of %0d nodes; over-long patterns and a full pattern store exercised",
               node_total);
      if (n_errors == 0 && expected.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[multi_pattern_matcher_core.f]
design/mpm_pkg.sv
design/mpm_front.sv
design/mpm_engine.sv
design/multi_pattern_matcher_core.sv
sim/multi_pattern_matcher_core_tb.sv
